// ===== rtl/core/esc_pkg.sv =====
// esc_pkg: shared types, register indexes and arithmetic helpers for the
// environmental sensor compensation block. No dependencies.
package esc_pkg;

  localparam int unsigned DivSteps = 32;

  localparam logic [2:0] CFG_TEMP_CAL  = 3'd0;
  localparam logic [2:0] CFG_PRESS_LOW = 3'd1;
  localparam logic [2:0] CFG_PRESS_MID = 3'd2;
  localparam logic [2:0] CFG_PRESS_HIGH = 3'd3;
  localparam logic [2:0] CFG_HUM_CAL   = 3'd4;

  localparam logic [31:0] PRESS_MAX = 32'd262143;
  localparam logic [31:0] HUM_MAX   = 32'd419430400;

  typedef struct packed {
    logic [47:0] temp_cal;
    logic [47:0] press_cal_low;
    logic [47:0] press_cal_mid;
    logic [47:0] press_cal_high;
    logic [63:0] hum_cal;
  } cal_t;

  // one divider stage: partial remainder, dividend/quotient word, divisor,
  // plus the finished side results riding along
  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] num;
    logic [31:0] den;
    logic        dbl;
    logic        inv;
    logic [15:0] tc;
    logic [16:0] hq;
  } div_cell_t;

  typedef struct packed {
    logic [15:0] tc;
    logic [17:0] pa;
    logic        inv;
    logic [16:0] hq;
  } res_t;

  // arithmetic right shift of a 32-bit two's complement word
  function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
    return $unsigned($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] x);
    return {{16{x[15]}}, x};
  endfunction

  function automatic logic [31:0] sx12(input logic [11:0] x);
    return {{20{x[11]}}, x};
  endfunction

  function automatic logic [31:0] sx8(input logic [7:0] x);
    return {{24{x[7]}}, x};
  endfunction

endpackage

// ===== rtl/core/esc_if.sv =====
// esc_if: valid/ready channel interfaces for samples, results and
// configuration writes. No dependencies.
interface esc_in_if;
  logic        valid;
  logic        ready;
  logic [19:0] raw_temperature;
  logic [19:0] raw_pressure;
  logic [15:0] raw_humidity;
  modport source (output valid, raw_temperature, raw_pressure, raw_humidity, input ready);
  modport sink   (input valid, raw_temperature, raw_pressure, raw_humidity, output ready);
endinterface

interface esc_out_if;
  logic        valid;
  logic        ready;
  logic signed [15:0] temperature_centi;
  logic [17:0] pressure_pa;
  logic        pressure_invalid;
  logic [16:0] humidity_q10;
  modport source (output valid, temperature_centi, pressure_pa, pressure_invalid,
                  humidity_q10, input ready);
  modport sink   (input valid, temperature_centi, pressure_pa, pressure_invalid,
                  humidity_q10, output ready);
endinterface

interface esc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  addr;
  logic [63:0] data;
  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

// ===== rtl/core/esc_front.sv =====
// esc_front: 14-stage pipeline for fine temperature, temperature, humidity
// and the pressure dividend/divisor. Depends on esc_pkg.
module esc_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  esc_pkg::cal_t         cal,
  input  logic                  vld_i,
  input  logic [19:0]           rt,
  input  logic [19:0]           rp,
  input  logic [15:0]           rh,
  output logic                  vld_o,
  output esc_pkg::div_cell_t    d_o
);

  logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, h1, h2, h3, h4, h5, h6;
  assign t1 = 32'(cal.temp_cal[15:0]);
  assign t2 = esc_pkg::sx16(cal.temp_cal[31:16]);
  assign t3 = esc_pkg::sx16(cal.temp_cal[47:32]);
  assign p1 = 32'(cal.press_cal_low[15:0]);
  assign p2 = esc_pkg::sx16(cal.press_cal_low[31:16]);
  assign p3 = esc_pkg::sx16(cal.press_cal_low[47:32]);
  assign p4 = esc_pkg::sx16(cal.press_cal_mid[15:0]);
  assign p5 = esc_pkg::sx16(cal.press_cal_mid[31:16]);
  assign p6 = esc_pkg::sx16(cal.press_cal_mid[47:32]);
  assign h1 = 32'(cal.hum_cal[7:0]);
  assign h2 = esc_pkg::sx16(cal.hum_cal[23:8]);
  assign h3 = 32'(cal.hum_cal[31:24]);
  assign h4 = esc_pkg::sx12(cal.hum_cal[43:32]);
  assign h5 = esc_pkg::sx12(cal.hum_cal[55:44]);
  assign h6 = esc_pkg::sx8(cal.hum_cal[63:56]);

  logic [13:0] vld_r;

  // stage registers
  logic [31:0] s1_ma_r, s1_mb_r;
  logic [19:0] s1_rp_r, s2_rp_r, s3_rp_r, s4_rp_r, s5_rp_r, s6_rp_r, s7_rp_r, s8_rp_r;
  logic [15:0] s1_rh_r, s2_rh_r, s3_rh_r, s4_rh_r;
  logic [31:0] s2_v1_r, s2_m3_r, s3_tf_r;
  logic [15:0] s4_tc_r, s5_tc_r, s6_tc_r, s7_tc_r, s8_tc_r, s9_tc_r, s10_tc_r, s11_tc_r;
  logic [15:0] s12_tc_r, s13_tc_r;
  logic [31:0] s4_pv1_r, s4_hv_r;
  logic [31:0] s5_qq_r, s5_m5_r, s5_m2_r, s5_hx_r, s5_hy_r, s5_hz_r;
  logic [31:0] s6_v2a_r, s6_m3p_r, s6_m5_r, s6_m2_r, s6_x_r, s6_y1_r, s6_z_r;
  logic [31:0] s7_v2_r, s7_v1_r, s7_yz_r, s7_x_r;
  logic [31:0] s8_d_r, s8_y2_r, s8_v2_r, s8_x_r;
  logic [31:0] s9_div_r, s9_pn_r, s9_yh_r, s9_x_r;
  logic [31:0] s10_pm_r, s10_y_r, s10_div_r, s10_x_r;
  logic [31:0] s11_num_r, s11_den_r, s11_hv_r, s12_num_r, s12_den_r, s12_hv_r;
  logic [31:0] s13_num_r, s13_den_r, s13_hv_r, s12_ss_r, s13_m_r;
  logic        s11_dbl_r, s11_inv_r, s12_dbl_r, s12_inv_r, s13_dbl_r, s13_inv_r;
  logic [16:0] s14_hq_r;
  esc_pkg::div_cell_t s14_d_r;

  // combinational helpers
  logic [31:0] ta, tb, tcw, pq, hs;
  assign ta  = (32'(rt) >> 3) - (t1 << 1);
  assign tb  = (32'(rt) >> 4) - t1;
  assign tcw = esc_pkg::asr(s3_tf_r * 32'd5 + 32'd128, 8);
  assign pq  = esc_pkg::asr(s4_pv1_r, 2);
  assign hs  = s13_hv_r - esc_pkg::asr(s13_m_r, 4);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[12:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // fine temperature
      s1_ma_r <= ta * t2;
      s1_mb_r <= tb * tb;
      s1_rp_r <= rp;
      s1_rh_r <= rh;
      s2_v1_r <= esc_pkg::asr(s1_ma_r, 11);
      s2_m3_r <= esc_pkg::asr(s1_mb_r, 12) * t3;
      s2_rp_r <= s1_rp_r;
      s2_rh_r <= s1_rh_r;
      s3_tf_r <= s2_v1_r + esc_pkg::asr(s2_m3_r, 14);
      s3_rp_r <= s2_rp_r;
      s3_rh_r <= s2_rh_r;
      // temperature output, pressure and humidity offsets
      if ($signed(tcw) > 32'sd32767) begin
        s4_tc_r <= 16'h7FFF;
      end else if ($signed(tcw) < -32'sd32768) begin
        s4_tc_r <= 16'h8000;
      end else begin
        s4_tc_r <= tcw[15:0];
      end
      s4_pv1_r <= esc_pkg::asr(s3_tf_r, 1) - 32'd64000;
      s4_hv_r  <= s3_tf_r - 32'd76800;
      s4_rp_r  <= s3_rp_r;
      s4_rh_r  <= s3_rh_r;
      // first products
      s5_qq_r <= pq * pq;
      s5_m5_r <= s4_pv1_r * p5;
      s5_m2_r <= p2 * s4_pv1_r;
      s5_hx_r <= (32'(s4_rh_r) << 14) - (h4 << 20) - h5 * s4_hv_r;
      s5_hy_r <= s4_hv_r * h6;
      s5_hz_r <= s4_hv_r * h3;
      s5_tc_r <= s4_tc_r;
      s5_rp_r <= s4_rp_r;
      s6_v2a_r <= esc_pkg::asr(s5_qq_r, 11) * p6;
      s6_m3p_r <= p3 * esc_pkg::asr(s5_qq_r, 13);
      s6_m5_r  <= s5_m5_r;
      s6_m2_r  <= s5_m2_r;
      s6_x_r   <= esc_pkg::asr(s5_hx_r + 32'd16384, 15);
      s6_y1_r  <= esc_pkg::asr(s5_hy_r, 10);
      s6_z_r   <= esc_pkg::asr(s5_hz_r, 11) + 32'd32768;
      s6_tc_r  <= s5_tc_r;
      s6_rp_r  <= s5_rp_r;
      s7_v2_r  <= esc_pkg::asr(s6_v2a_r + (s6_m5_r << 1), 2) + (p4 << 16);
      s7_v1_r  <= esc_pkg::asr(esc_pkg::asr(s6_m3p_r, 3) + esc_pkg::asr(s6_m2_r, 1), 18);
      s7_yz_r  <= s6_y1_r * s6_z_r;
      s7_x_r   <= s6_x_r;
      s7_tc_r  <= s6_tc_r;
      s7_rp_r  <= s6_rp_r;
      s8_d_r   <= (32'd32768 + s7_v1_r) * p1;
      s8_y2_r  <= esc_pkg::asr(s7_yz_r, 10) + 32'd2097152;
      s8_v2_r  <= s7_v2_r;
      s8_x_r   <= s7_x_r;
      s8_tc_r  <= s7_tc_r;
      s8_rp_r  <= s7_rp_r;
      s9_div_r <= esc_pkg::asr(s8_d_r, 15);
      s9_pn_r  <= 32'd1048576 - 32'(s8_rp_r) - esc_pkg::asr(s8_v2_r, 12);
      s9_yh_r  <= s8_y2_r * h2;
      s9_x_r   <= s8_x_r;
      s9_tc_r  <= s8_tc_r;
      s10_pm_r  <= s9_pn_r * 32'd3125;
      s10_y_r   <= esc_pkg::asr(s9_yh_r + 32'd8192, 14);
      s10_div_r <= s9_div_r;
      s10_x_r   <= s9_x_r;
      s10_tc_r  <= s9_tc_r;
      // division setup: large values divide first and double after
      s11_num_r <= s10_pm_r[31] ? s10_pm_r : (s10_pm_r << 1);
      s11_dbl_r <= s10_pm_r[31];
      s11_den_r <= s10_div_r;
      s11_inv_r <= (s10_div_r == '0);
      s11_hv_r  <= s10_x_r * s10_y_r;
      s11_tc_r  <= s10_tc_r;
      s12_ss_r  <= esc_pkg::asr(s11_hv_r, 15) * esc_pkg::asr(s11_hv_r, 15);
      s12_hv_r  <= s11_hv_r;
      s12_num_r <= s11_num_r;
      s12_den_r <= s11_den_r;
      s12_dbl_r <= s11_dbl_r;
      s12_inv_r <= s11_inv_r;
      s12_tc_r  <= s11_tc_r;
      s13_m_r   <= esc_pkg::asr(s12_ss_r, 7) * h1;
      s13_hv_r  <= s12_hv_r;
      s13_num_r <= s12_num_r;
      s13_den_r <= s12_den_r;
      s13_dbl_r <= s12_dbl_r;
      s13_inv_r <= s12_inv_r;
      s13_tc_r  <= s12_tc_r;
      // humidity clamp to 0..100 percent
      if (hs[31]) begin
        s14_hq_r <= '0;
      end else if (hs > esc_pkg::HUM_MAX) begin
        s14_hq_r <= esc_pkg::HUM_MAX[28:12];
      end else begin
        s14_hq_r <= hs[28:12];
      end
      s14_d_r.rem <= '0;
      s14_d_r.num <= s13_num_r;
      s14_d_r.den <= s13_den_r;
      s14_d_r.dbl <= s13_dbl_r;
      s14_d_r.inv <= s13_inv_r;
      s14_d_r.tc  <= s13_tc_r;
      s14_d_r.hq  <= '0;
    end
  end

  assign vld_o = vld_r[13];
  always_comb begin
    d_o    = s14_d_r;
    d_o.hq = s14_hq_r;
  end

endmodule

// ===== rtl/core/esc_div_cell.sv =====
// esc_div_cell: one restoring division step, registered; cells are chained
// to form the pressure divider. Depends on esc_pkg.
module esc_div_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  vld_i,
  input  esc_pkg::div_cell_t    d_i,
  output logic                  vld_o,
  output esc_pkg::div_cell_t    d_o
);

  logic               vld_r;
  esc_pkg::div_cell_t d_r, d_nxt;
  logic [32:0]        rsh;
  logic [32:0]        diff;

  assign rsh  = {d_i.rem, d_i.num[31]};
  assign diff = rsh - {1'b0, d_i.den};

  always_comb begin
    d_nxt = d_i;
    if (!diff[32]) begin
      d_nxt.rem = diff[31:0];
      d_nxt.num = {d_i.num[30:0], 1'b1};
    end else begin
      d_nxt.rem = rsh[31:0];
      d_nxt.num = {d_i.num[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign vld_o = vld_r;
  assign d_o   = d_r;

endmodule

// ===== rtl/core/esc_post.sv =====
// esc_post: 3-stage pressure correction after the divider, with saturation
// and the invalid override. Depends on esc_pkg.
module esc_post (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  esc_pkg::cal_t         cal,
  input  logic                  vld_i,
  input  esc_pkg::div_cell_t    d_i,
  output logic                  vld_o,
  output esc_pkg::res_t         r_o
);

  logic [31:0] p7, p8, p9, pq, pin, pf;
  logic [2:0]  vld_r;
  logic [31:0] b1_p_r, b1_a_r, b1_b_r, b2_p_r, b2_a_r, b2_b_r;
  logic [15:0] b1_tc_r, b2_tc_r;
  logic [16:0] b1_hq_r, b2_hq_r;
  logic        b1_inv_r, b2_inv_r;
  esc_pkg::res_t r_r;

  assign p7  = esc_pkg::sx16(cal.press_cal_high[15:0]);
  assign p8  = esc_pkg::sx16(cal.press_cal_high[31:16]);
  assign p9  = esc_pkg::sx16(cal.press_cal_high[47:32]);
  assign pin = d_i.dbl ? (d_i.num << 1) : d_i.num;
  assign pq  = pin >> 3;
  assign pf  = b2_p_r + esc_pkg::asr(b2_a_r + b2_b_r + p7, 4);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_p_r   <= pin;
      b1_a_r   <= pq * pq;
      b1_b_r   <= (pin >> 2) * p8;
      b1_tc_r  <= d_i.tc;
      b1_hq_r  <= d_i.hq;
      b1_inv_r <= d_i.inv;
      b2_p_r   <= b1_p_r;
      b2_a_r   <= esc_pkg::asr(p9 * (b1_a_r >> 13), 12);
      b2_b_r   <= esc_pkg::asr(b1_b_r, 13);
      b2_tc_r  <= b1_tc_r;
      b2_hq_r  <= b1_hq_r;
      b2_inv_r <= b1_inv_r;
      r_r.tc   <= b2_tc_r;
      r_r.hq   <= b2_hq_r;
      r_r.inv  <= b2_inv_r;
      if (b2_inv_r) begin
        r_r.pa <= '0;
      end else if (pf > esc_pkg::PRESS_MAX) begin
        r_r.pa <= esc_pkg::PRESS_MAX[17:0];
      end else begin
        r_r.pa <= pf[17:0];
      end
    end
  end

  assign vld_o = vld_r[2];
  assign r_o   = r_r;

endmodule

// ===== rtl/core/env_sensor_compensation.sv =====
// env_sensor_compensation: top level of the pressure/temperature/humidity
// compensation block. Depends on esc_pkg, esc_if, esc_front, esc_div_cell, esc_post.
//
// Usage:
//   in_port  : one raw sample set per transaction (temperature, pressure,
//              humidity readings).
//   out_port : one compensated result per transaction, in input order.
//   cfg_port : register writes (addr 0..4 = temp, press low/mid/high, hum
//              calibration); always ready, unknown addresses are dropped.
//              Write only while no sample is in flight.
// Throughput: one sample set per cycle while out_port is not stalled.
// Pipeline: input transaction to out_port.valid passes 14 front
//   stages, a chain of 32 divider cells (one quotient bit each), 3
//   correction stages and the output register.
// Reset: synchronous rst_n clears all pipeline valid bits, the output and
//   skid valid bits and all calibration registers to zero.
// Stall: when out_port.ready is low while a result is held, the output register
//   holds; the next arriving result parks in a skid register, and only then
//   does the whole pipeline freeze and in_port.ready drop.
module env_sensor_compensation (
  input  logic        clk,
  input  logic        rst_n,
  esc_in_if.sink      in_port,
  esc_out_if.source   out_port,
  esc_cfg_if.sink     cfg_port
);

  esc_pkg::cal_t cal_r;
  logic          en;

  // calibration registers
  assign cfg_port.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= '0;
    end else if (cfg_port.valid) begin
      case (cfg_port.addr)
        esc_pkg::CFG_TEMP_CAL:   cal_r.temp_cal       <= cfg_port.data[47:0];
        esc_pkg::CFG_PRESS_LOW:  cal_r.press_cal_low  <= cfg_port.data[47:0];
        esc_pkg::CFG_PRESS_MID:  cal_r.press_cal_mid  <= cfg_port.data[47:0];
        esc_pkg::CFG_PRESS_HIGH: cal_r.press_cal_high <= cfg_port.data[47:0];
        esc_pkg::CFG_HUM_CAL:    cal_r.hum_cal        <= cfg_port.data;
        default: ;
      endcase
    end
  end

  // front pipeline
  logic               fr_vld;
  esc_pkg::div_cell_t fr_d;

  assign in_port.ready = en;

  esc_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .cal   (cal_r),
    .vld_i (in_port.valid),
    .rt    (in_port.raw_temperature),
    .rp    (in_port.raw_pressure),
    .rh    (in_port.raw_humidity),
    .vld_o (fr_vld),
    .d_o   (fr_d)
  );

  // divider chain, one quotient bit per cell
  logic               dv_vld [esc_pkg::DivSteps+1];
  esc_pkg::div_cell_t dv_d   [esc_pkg::DivSteps+1];

  assign dv_vld[0] = fr_vld;
  assign dv_d[0]   = fr_d;

  for (genvar i = 0; i < esc_pkg::DivSteps; i++) begin : g_div
    esc_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .vld_i (dv_vld[i]),
      .d_i   (dv_d[i]),
      .vld_o (dv_vld[i+1]),
      .d_o   (dv_d[i+1])
    );
  end

  // pressure correction
  logic          po_vld;
  esc_pkg::res_t po_r;

  esc_post u_post (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .cal   (cal_r),
    .vld_i (dv_vld[esc_pkg::DivSteps]),
    .d_i   (dv_d[esc_pkg::DivSteps]),
    .vld_o (po_vld),
    .r_o   (po_r)
  );

  // output register plus skid register
  logic          ov_r, sv_r;
  esc_pkg::res_t od_r, sd_r;

  assign en = !sv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      sv_r <= 1'b0;
    end else if (en) begin
      if (ov_r && !out_port.ready) begin
        sv_r <= po_vld;
      end else begin
        ov_r <= po_vld;
      end
    end else if (out_port.ready) begin
      ov_r <= 1'b1;
      sv_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (ov_r && !out_port.ready) begin
        sd_r <= po_r;
      end else begin
        od_r <= po_r;
      end
    end else if (out_port.ready) begin
      od_r <= sd_r;
    end
  end

  assign out_port.valid             = ov_r;
  assign out_port.temperature_centi = od_r.tc;
  assign out_port.pressure_pa       = od_r.pa;
  assign out_port.pressure_invalid  = od_r.inv;
  assign out_port.humidity_q10      = od_r.hq;

endmodule

// ===== dv/env_sensor_compensation_tb.sv =====
// env_sensor_compensation_tb: self-checking bench for the sensor compensation
// block. Drives sample sets and calibration writes and checks every result.
// Depends on esc_pkg, esc_if and env_sensor_compensation.
module env_sensor_compensation_tb;

  // ---------------------------------------------------------------------------
  // Clock, reset, and the three channels
  // ---------------------------------------------------------------------------
  logic clk;
  logic rst_n;

  esc_in_if  in_ch ();
  esc_out_if out_ch ();
  esc_cfg_if cfg_ch ();

  env_sensor_compensation i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_port  (in_ch.sink),
    .out_port (out_ch.source),
    .cfg_port (cfg_ch.sink)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned DrainCycles   = 60;    // pipeline latency plus margin

  // Shadow copy of the calibration registers, used by the predictor
  esc_pkg::cal_t cal_shadow;

  // Expected result store, oldest first
  esc_pkg::res_t expected_results[$];

  int  n_mismatch;
  bit  idle_enable;     // random bubbles on both sides when set
  int  idle_cnt;        // cycles without any transaction, for the watchdog

  // ---------------------------------------------------------------------------
  // Predictor: 32-bit two's complement integer compensation.
  // All intermediates wrap at 32 bits; >>> on signed gives arithmetic shift.
  // ---------------------------------------------------------------------------
  function automatic esc_pkg::res_t compensate(input esc_pkg::cal_t c,
                                               input logic [19:0] rt,
                                               input logic [19:0] rp,
                                               input logic [15:0] rh);
    logic signed [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic signed [31:0] h1, h2, h3, h4, h5, h6;
    logic signed [31:0] a, b, v1, v2, tf, q, qq, x, y, z, v, s, tcw;
    logic        [31:0] p, den;
    logic signed [63:0] hs;
    esc_pkg::res_t r;
    t1 = {16'd0, c.temp_cal[15:0]};
    t2 = {{16{c.temp_cal[31]}}, c.temp_cal[31:16]};
    t3 = {{16{c.temp_cal[47]}}, c.temp_cal[47:32]};
    p1 = {16'd0, c.press_cal_low[15:0]};
    p2 = {{16{c.press_cal_low[31]}}, c.press_cal_low[31:16]};
    p3 = {{16{c.press_cal_low[47]}}, c.press_cal_low[47:32]};
    p4 = {{16{c.press_cal_mid[15]}}, c.press_cal_mid[15:0]};
    p5 = {{16{c.press_cal_mid[31]}}, c.press_cal_mid[31:16]};
    p6 = {{16{c.press_cal_mid[47]}}, c.press_cal_mid[47:32]};
    p7 = {{16{c.press_cal_high[15]}}, c.press_cal_high[15:0]};
    p8 = {{16{c.press_cal_high[31]}}, c.press_cal_high[31:16]};
    p9 = {{16{c.press_cal_high[47]}}, c.press_cal_high[47:32]};
    h1 = {24'd0, c.hum_cal[7:0]};
    h2 = {{16{c.hum_cal[23]}}, c.hum_cal[23:8]};
    h3 = {24'd0, c.hum_cal[31:24]};
    h4 = {{20{c.hum_cal[43]}}, c.hum_cal[43:32]};
    h5 = {{20{c.hum_cal[55]}}, c.hum_cal[55:44]};
    h6 = {{24{c.hum_cal[63]}}, c.hum_cal[63:56]};

    // temperature and fine temperature
    a  = $signed({12'd0, rt} >> 3) - (t1 <<< 1);
    v1 = (a * t2) >>> 11;
    b  = $signed({12'd0, rt} >> 4) - t1;
    v2 = (((b * b) >>> 12) * t3) >>> 14;
    tf = v1 + v2;
    tcw = (tf * 5 + 128) >>> 8;
    if (tcw > 32767)       r.tc = 16'h7fff;
    else if (tcw < -32768) r.tc = 16'h8000;
    else                   r.tc = tcw[15:0];

    // pressure
    v1 = (tf >>> 1) - 64000;
    q  = v1 >>> 2;
    qq = q * q;
    v2 = (qq >>> 11) * p6;
    v2 = v2 + ((v1 * p5) <<< 1);
    v2 = (v2 >>> 2) + (p4 <<< 16);
    v1 = (((p3 * (qq >>> 13)) >>> 3) + ((p2 * v1) >>> 1)) >>> 18;
    v1 = ((32768 + v1) * p1) >>> 15;
    if (v1 == 0) begin
      r.inv = 1'b1;
      r.pa  = '0;
    end else begin
      r.inv = 1'b0;
      den = v1;
      p = (32'd1048576 - {12'd0, rp} - $unsigned(v2 >>> 12)) * 32'd3125;
      if (p < 32'h8000_0000) p = (p << 1) / den;
      else                   p = (p / den) * 32'd2;
      a = (p9 * $signed(((p >> 3) * (p >> 3)) >> 13)) >>> 12;
      b = ($signed(p >> 2) * p8) >>> 13;
      p = p + $unsigned((a + b + p7) >>> 4);
      r.pa = (p > esc_pkg::PRESS_MAX) ? 18'h3ffff : p[17:0];
    end

    // humidity
    v = tf - 76800;
    x = ((($signed({16'd0, rh}) <<< 14) - (h4 <<< 20) - (h5 * v)) + 16384) >>> 15;
    y = (v * h6) >>> 10;
    z = ((v * h3) >>> 11) + 32768;
    y = ((y * z) >>> 10) + 2097152;
    y = ((y * h2) + 8192) >>> 14;
    v = x * y;
    s = v >>> 15;
    v = v - ((((s * s) >>> 7) * h1) >>> 4);
    hs = v;
    if (hs < 0) hs = 0;
    if (hs > 419430400) hs = 419430400;
    r.hq = hs[28:12];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Mismatch reporting
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input longint got, input longint exp);
    $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, exp);
    n_mismatch++;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random backpressure and in-order comparison
  // ---------------------------------------------------------------------------
  int out_stall;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected transaction", 1, 0);
        end else begin
          esc_pkg::res_t e;
          e = expected_results.pop_front();
          if (out_ch.temperature_centi !== e.tc)
            report_mismatch("temperature_centi", $signed(out_ch.temperature_centi),
                            $signed(e.tc));
          if (out_ch.pressure_pa !== e.pa)
            report_mismatch("pressure_pa", out_ch.pressure_pa, e.pa);
          if (out_ch.pressure_invalid !== e.inv)
            report_mismatch("pressure_invalid", out_ch.pressure_invalid, e.inv);
          if (out_ch.humidity_q10 !== e.hq)
            report_mismatch("humidity_q10", out_ch.humidity_q10, e.hq);
        end
      end
      // random stall bursts on ready, counted down in out_stall
      if (out_stall > 0) begin
        out_stall--;
        out_ch.ready <= (out_stall == 0);
      end else if (idle_enable && $urandom_range(0, 9) == 0) begin
        out_stall = $urandom_range(1, 5);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: cycles with no transaction on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= WatchdogLimit) begin
        $display("watchdog expired with %0d results outstanding", expected_results.size());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender tasks
  // ---------------------------------------------------------------------------
  // Send one sample set; valid stays high back to back, drops only for a gap.
  task automatic send_sample(input logic [19:0] rt, input logic [19:0] rp,
                             input logic [15:0] rh);
    int gap;
    if (idle_enable && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 5);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.raw_temperature <= rt;
    in_ch.raw_pressure    <= rp;
    in_ch.raw_humidity    <= rh;
    do @(posedge clk); while (!in_ch.ready);
    expected_results.push_back(compensate(cal_shadow, rt, rp, rh));
  endtask

  // Drop valid, wait for all results, then wait a further drain margin.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Register write; only called while the pipeline is empty.
  // cfg valid is dropped after each write, before the task returns.
  task automatic write_cal(input logic [2:0] idx, input logic [63:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr  <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      esc_pkg::CFG_TEMP_CAL:   cal_shadow.temp_cal       = value[47:0];
      esc_pkg::CFG_PRESS_LOW:  cal_shadow.press_cal_low  = value[47:0];
      esc_pkg::CFG_PRESS_MID:  cal_shadow.press_cal_mid  = value[47:0];
      esc_pkg::CFG_PRESS_HIGH: cal_shadow.press_cal_high = value[47:0];
      esc_pkg::CFG_HUM_CAL:    cal_shadow.hum_cal        = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic load_cal(input logic [63:0] tc, input logic [63:0] pl,
                          input logic [63:0] pm, input logic [63:0] ph,
                          input logic [63:0] hc);
    write_cal(esc_pkg::CFG_TEMP_CAL, tc);
    write_cal(esc_pkg::CFG_PRESS_LOW, pl);
    write_cal(esc_pkg::CFG_PRESS_MID, pm);
    write_cal(esc_pkg::CFG_PRESS_HIGH, ph);
    write_cal(esc_pkg::CFG_HUM_CAL, hc);
  endtask

  // Calibration close to a typical real part, with small random spread.
  function automatic logic [63:0] pack3(input int a, input int b, input int c);
    return {16'd0, c[15:0], b[15:0], a[15:0]};
  endfunction

  task automatic load_typical_cal();
    load_cal(pack3(27504 + $urandom_range(0, 2000), 26435 + $urandom_range(0, 500), -1000),
             pack3(36477 + $urandom_range(0, 2000), -10685, 3024),
             pack3(2855, 140, -7),
             pack3(15500, -14600, 6000),
             {8'd30, 12'd0, 12'd339, 8'd0, 16'd362, 8'd75} +
             {32'd0, 8'd0, 16'($urandom_range(0, 100)), 8'd0});
  endtask

  // Random sample near a realistic operating point, or fully random noise.
  task automatic send_random_sample(input bit realistic);
    if (realistic)
      send_sample(20'($urandom_range(480000, 560000)), 20'($urandom_range(300000, 450000)),
                  16'($urandom_range(20000, 40000)));
    else
      send_sample(20'($urandom), 20'($urandom), 16'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset calibration is all zero: divisor is zero, so pressure is invalid.
  task automatic test_reset_calibration();
    send_sample(20'd0, 20'd0, 16'd0);
    send_sample(20'hfffff, 20'hfffff, 16'hffff);
    send_sample(20'd519888, 20'd415148, 16'd30000);
    drain_results();
  endtask

  // Field extremes and saturation corners under realistic calibration.
  task automatic test_field_extremes();
    load_typical_cal();
    send_sample(20'd0, 20'd0, 16'd0);
    send_sample(20'hfffff, 20'hfffff, 16'hffff);
    send_sample(20'd0, 20'hfffff, 16'hffff);
    send_sample(20'hfffff, 20'd0, 16'd0);
    send_sample(20'h55555, 20'haaaaa, 16'h5555);
    send_sample(20'haaaaa, 20'h55555, 16'haaaa);
    send_sample(20'd519888, 20'd415148, 16'd30000);
    send_sample(20'd519888, 20'd1, 16'd65535);
    drain_results();
  endtask

  // Calibration extremes: all ones and sign-bit-only words, with big wraps.
  task automatic test_cal_extremes();
    load_cal('1, '1, '1, '1, '1);
    send_sample(20'd0, 20'd0, 16'd0);
    send_sample(20'hfffff, 20'hfffff, 16'hffff);
    drain_results();
    load_cal(64'h8000_8000_ffff, 64'h8000_8000_ffff, 64'h8000_8000_8000,
             64'h8000_8000_8000, 64'h80_800_800_ff_8000_ff);
    send_sample(20'd0, 20'd0, 16'd0);
    send_sample(20'hfffff, 20'hfffff, 16'hffff);
    send_sample(20'd519888, 20'd415148, 16'd30000);
    drain_results();
    // unknown index must be dropped
    write_cal(3'd7, '1);
    write_cal(3'd5, 64'h1234);
    send_sample(20'd519888, 20'd415148, 16'd30000);
    drain_results();
  endtask

  // Random sample sets over several random and typical calibrations.
  task automatic test_random(input int n_sets, input int n_per_set);
    for (int k = 0; k < n_sets; k++) begin
      if (k % 3 == 2)
        load_cal({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom}, {$urandom, $urandom});
      else
        load_typical_cal();
      for (int i = 0; i < n_per_set; i++)
        send_random_sample($urandom_range(0, 9) < 8);
      // the full pause: sender holds off until every result is back
      drain_results();
    end
  endtask

  // Last stretch: no idling, full rate.
  task automatic test_full_rate();
    idle_enable = 1'b0;
    load_typical_cal();
    for (int i = 0; i < 300; i++) send_random_sample($urandom_range(0, 9) < 8);
    drain_results();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    n_mismatch  = 0;
    idle_enable = 1'b1;
    cal_shadow  = '0;
    rst_n = 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.raw_temperature <= '0;
    in_ch.raw_pressure    <= '0;
    in_ch.raw_humidity    <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.addr  <= '0;
    cfg_ch.data  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_calibration();
    test_field_extremes();
    test_cal_extremes();
    test_random(12, 140);
    test_full_rate();

    if (n_mismatch == 0) $display("end of test: clean");
    else                 $display("end of test: mismatches");
    $finish;
  end

endmodule
